FILE: rtl/pld_pkg.sv
// Package for the point-to-line distance block: widths, payload and pipeline types.
`default_nettype none
package pld_pkg;
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CABS_W     = 2 * COORD_BITS + 2;
    localparam int LEN_W      = 2 * COORD_BITS + 1;
    localparam int DIST_BITS  = 17;
    localparam int REM_W      = 2 * CABS_W + 1;
    localparam int QL_W       = LEN_W + DIST_BITS;
    localparam int IDX_W      = $clog2(DIST_BITS);
    localparam int SH_W       = IDX_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } query_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] perp_distance;
        logic                 degenerate;
    } result_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [QL_W-1:0]      ql;
        logic [LEN_W-1:0]     len;
        logic [DIST_BITS-1:0] q;
        logic                 degen;
    } cell_data_t;
endpackage
`default_nettype wire

FILE: rtl/point_line_distance.sv
// Top level: perpendicular distance from a point to the line through two ends.
//
// Requests arrive on query (valid/ready) holding point, start and end as signed
// coordinates. Each yields one result on result (valid/ready): the distance
// floor(|C| / sqrt(L)) and a degenerate flag, set with distance 0 when both
// ends coincide.
// From acceptance to result valid there are 21 register stages, the first
// loaded at acceptance: 4 front stages (differences, products, sums,
// squaring of the cross term) then one cell per distance bit, 17 cells, each
// holding one request.
// Throughput is one request per cycle. Every stage has its own valid bit and
// moves when the stage after it is empty or moving, so bubbles close up and
// requests keep entering while a result waits on a stalled receiver; query_ready
// drops only when all 21 stages are full.
// Reset clears all valid bits; no results are pending afterward.
`default_nettype none
module point_line_distance import pld_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    query_valid,
    output logic         query_ready,
    input  wire query_t  query,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);
    logic       chain_valid [DIST_BITS+1];
    logic       chain_ready [DIST_BITS+1];
    cell_data_t chain_data  [DIST_BITS+1];

    pld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .dn_valid    (chain_valid[0]),
        .dn_ready    (chain_ready[0]),
        .dn          (chain_data[0])
    );

    for (genvar i = 0; i < DIST_BITS; i++)
    begin : g_cell
        pld_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bit_idx  (IDX_W'(DIST_BITS - 1 - i)),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up       (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn       (chain_data[i+1])
        );
    end

    assign chain_ready[DIST_BITS] = result_ready;
    assign result_valid           = chain_valid[DIST_BITS];
    assign result.degenerate      = chain_data[DIST_BITS].degen;
    assign result.perp_distance   = chain_data[DIST_BITS].degen ? '0 : chain_data[DIST_BITS].q;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |-> result.perp_distance == '0)
        else $error("degenerate result with nonzero distance");

    a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !query_ready |-> result_valid && !result_ready)
        else $error("input blocked while output drains");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: rtl/pld_front.sv
// Front pipeline: differences, products, cross term and squared length, squared cross term.
`default_nettype none
module pld_front import pld_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       query_valid,
    output logic            query_ready,
    input  wire query_t     query,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output cell_data_t      dn
);
    logic [3:0] valid_reg;
    logic [3:0] adv;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, u_reg, v_reg;
    logic                     degen1_reg, degen2_reg, degen3_reg, degen4_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;
    logic [LEN_W-1:0]         sqx_reg, sqy_reg;
    logic [CABS_W-1:0]        cabs_reg;
    logic [LEN_W-1:0]         len3_reg, len4_reg;
    logic [REM_W-1:0]         c2_reg;

    logic signed [DIFF_W-1:0] dx_next, dy_next, u_next, v_next;
    logic signed [PROD_W:0]   c_next;
    logic [PROD_W-1:0]        sqx_full, sqy_full;

    assign adv[3] = !valid_reg[3] || dn_ready;
    assign adv[2] = !valid_reg[2] || adv[3];
    assign adv[1] = !valid_reg[1] || adv[2];
    assign adv[0] = !valid_reg[0] || adv[1];
    assign query_ready = adv[0];

    always_comb
    begin
        dx_next = DIFF_W'(query.end_x) - DIFF_W'(query.start_x);
        dy_next = DIFF_W'(query.end_y) - DIFF_W'(query.start_y);
        u_next  = DIFF_W'(query.point_y) - DIFF_W'(query.start_y);
        v_next  = DIFF_W'(query.point_x) - DIFF_W'(query.start_x);
        sqx_full = PROD_W'(dx_reg * dx_reg);
        sqy_full = PROD_W'(dy_reg * dy_reg);
        c_next   = (PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0]) valid_reg[0] <= query_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            degen1_reg <= (dx_next == '0) && (dy_next == '0);
        end
        if (adv[1])
        begin
            p1_reg     <= dx_reg * u_reg;
            p2_reg     <= dy_reg * v_reg;
            sqx_reg    <= sqx_full[LEN_W-1:0];
            sqy_reg    <= sqy_full[LEN_W-1:0];
            degen2_reg <= degen1_reg;
        end
        if (adv[2])
        begin
            cabs_reg   <= c_next[PROD_W] ? CABS_W'(-c_next) : CABS_W'(c_next);
            len3_reg   <= sqx_reg + sqy_reg;
            degen3_reg <= degen2_reg;
        end
        if (adv[3])
        begin
            c2_reg     <= REM_W'(cabs_reg * cabs_reg);
            len4_reg   <= len3_reg;
            degen4_reg <= degen3_reg;
        end
    end

    assign dn_valid = valid_reg[3];
    assign dn.rem   = c2_reg;
    assign dn.ql    = '0;
    assign dn.len   = len4_reg;
    assign dn.q     = '0;
    assign dn.degen = degen4_reg;
endmodule
`default_nettype wire

FILE: rtl/pld_cell.sv
// One bit cell of the quotient chain: tries one bit of q against rem = C^2 - q^2 * L.
`default_nettype none
module pld_cell import pld_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] bit_idx,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire cell_data_t       up,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output cell_data_t            dn
);
    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;
    logic [REM_W-1:0] delta;
    logic [SH_W-1:0]  sh_q;
    logic [SH_W-1:0]  sh_l;

    assign up_ready = !valid_reg || dn_ready;

    // (q + 2^b)^2 L - q^2 L = q L 2^(b+1) + L 2^(2b)
    always_comb
    begin
        sh_q  = SH_W'(bit_idx) + SH_W'(1);
        sh_l  = {bit_idx, 1'b0};
        delta = (REM_W'(up.ql) << sh_q) + (REM_W'(up.len) << sh_l);
        data_next = up;
        if (delta <= up.rem)
        begin
            data_next.rem = up.rem - delta;
            data_next.ql  = up.ql + (QL_W'(up.len) << bit_idx);
            data_next.q   = up.q | (DIST_BITS'(1) << bit_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;
endmodule
`default_nettype wire
